// ===== sv/wsn_pkg.sv =====
// ----------------------------------------------------------------------------
// wsn_pkg: shared types and constants of the waveform shaper
// Shape codes, sample type and the noise generator's reset values.
// ----------------------------------------------------------------------------
package wsn_pkg;

  // Width of the shape selection register.
  localparam int SHAPE_W = 3;

  // Width of one output sample (Q1.15).
  localparam int SAMPLE_W = 16;

  typedef logic [SHAPE_W-1:0] shape_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Shape codes; the remaining codes produce a zero sample.
  localparam shape_t SHAPE_SINE     = 3'd0;
  localparam shape_t SHAPE_SQUARE   = 3'd1;
  localparam shape_t SHAPE_SAW      = 3'd2;
  localparam shape_t SHAPE_TRIANGLE = 3'd3;
  localparam shape_t SHAPE_NOISE    = 3'd4;

  // Largest positive Q1.15 value.
  localparam sample_t Q15_MAX = 16'sh7fff;

  // Reset values of the two noise registers.
  localparam logic [31:0] NOISE_MIX_RESET = 32'h70f4f854;
  localparam logic [31:0] NOISE_SUM_RESET = 32'he1e9f0a7;

endpackage

// ===== sv/waveform_shaper_with_noise.sv =====
// ----------------------------------------------------------------------------
// waveform_shaper_with_noise: phase to Q1.15 waveform sample
// Converts each phase request into one sample of the configured shape.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the result side does not
// stall, and returns one sample per request: the phase is captured in an
// input register, the shape logic (quarter-wave sine table, ramps, noise
// generator) works on it combinationally, and the sample waits in the result
// register until it is taken. With out_tready held high it sustains one
// request per cycle. The user must write the shape register through cfg_wr_en
// only while no request is in flight; the block does not enforce this. The
// noise generator advances only on requests handled in the noise shape.
module waveform_shaper_with_noise #(
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration: shape code.
  input  logic                          cfg_wr_en,
  input  logic [wsn_pkg::SHAPE_W-1:0]   cfg_wr_data,
  // Request channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] phase_word
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata   // [15:0] sample_out
);

  wsn_pkg::shape_t         shape_r;
  logic                    s1_valid_r;
  logic [PHASE_BITS-1:0]   phase_r;
  logic                    s1_move;
  logic                    out_valid_r;
  wsn_pkg::sample_t        sample_r;
  wsn_pkg::sample_t        sample_nxt;
  logic                    noise_step;
  wsn_pkg::sample_t        sine_val;
  wsn_pkg::sample_t        square_val;
  wsn_pkg::sample_t        saw_val;
  wsn_pkg::sample_t        tri_val;
  wsn_pkg::sample_t        noise_val;

  // Shape register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= wsn_pkg::SHAPE_SINE;
    end else if (cfg_wr_en) begin
      shape_r <= cfg_wr_data;
    end
  end

  // Flow control: the input stage moves when the result register is free or its sample is taken.
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      phase_r <= PHASE_BITS'(in_tdata);
    end
  end

  // Shape units.
  wsn_sine #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .phase  (phase_r),
    .sample (sine_val)
  );

  wsn_ramp #(
    .PHASE_BITS (PHASE_BITS)
  ) u_ramp (
    .phase    (phase_r),
    .square   (square_val),
    .saw      (saw_val),
    .triangle (tri_val)
  );

  assign noise_step = s1_move && (shape_r == wsn_pkg::SHAPE_NOISE);

  wsn_noise u_noise (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (noise_step),
    .sample (noise_val)
  );

  // Shape selection.
  always_comb begin
    case (shape_r)
      wsn_pkg::SHAPE_SINE:     sample_nxt = sine_val;
      wsn_pkg::SHAPE_SQUARE:   sample_nxt = square_val;
      wsn_pkg::SHAPE_SAW:      sample_nxt = saw_val;
      wsn_pkg::SHAPE_TRIANGLE: sample_nxt = tri_val;
      wsn_pkg::SHAPE_NOISE:    sample_nxt = noise_val;
      default:                 sample_nxt = '0;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sample_r;

  // A request leaving the input stage always lands in the result register.
  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("request lost between input and result register");

  // The input side stalls only when both stages are full and the result is not taken.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with free space");

  // Unused shape codes give a zero sample.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (shape_r > wsn_pkg::SHAPE_NOISE) |=> sample_r == '0)
    else $error("unused shape code gave a nonzero sample");

endmodule

// ===== sv/wsn_sine.sv =====
// ----------------------------------------------------------------------------
// wsn_sine: quarter-wave sine lookup
// Splits the phase into quadrant and table index, mirrors the index in odd
// quadrants and negates the table entry in the second half of the turn.
// ----------------------------------------------------------------------------
module wsn_sine #(
  parameter int PHASE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic [PHASE_BITS-1:0] phase,
  output wsn_pkg::sample_t      sample
);

  localparam int KW     = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int PROD_W = PHASE_BITS + KW;
  localparam int IW     = $clog2(SINE_TABLE_DEPTH + 1);

  // Table entry j as round(32767 * sin(pi/2 * j / depth)), where the sine is
  // the nested Taylor polynomial up to x^13 in Q30. Evaluated at elaboration.
  function automatic logic [15:0] sine_entry(input int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'd1686629713 * 64'(j)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd156;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s * 64'd32767 + 64'd536870912) >> 30;
    return r[15:0];
  endfunction

  logic [15:0]       sine_tab [0:SINE_TABLE_DEPTH];
  logic [PROD_W-1:0] prod;
  logic [KW-1:0]     k;
  logic [1:0]        quad;
  logic [KW-1:0]     quad_base;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     tab_addr;
  logic [15:0]       entry;

  // Constant quarter-wave table.
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    assign sine_tab[g] = sine_entry(g);
  end

  // Scale the phase to four table lengths per turn.
  assign prod = PROD_W'(phase) * PROD_W'(4 * SINE_TABLE_DEPTH);
  assign k    = prod[PHASE_BITS +: KW];

  // Quadrant by comparison with the table length multiples.
  always_comb begin
    if (k >= KW'(3 * SINE_TABLE_DEPTH)) begin
      quad      = 2'd3;
      quad_base = KW'(3 * SINE_TABLE_DEPTH);
    end else if (k >= KW'(2 * SINE_TABLE_DEPTH)) begin
      quad      = 2'd2;
      quad_base = KW'(2 * SINE_TABLE_DEPTH);
    end else if (k >= KW'(SINE_TABLE_DEPTH)) begin
      quad      = 2'd1;
      quad_base = KW'(SINE_TABLE_DEPTH);
    end else begin
      quad      = 2'd0;
      quad_base = '0;
    end
  end

  // Mirror the index in the odd quadrants, negate in the second half turn.
  assign idx      = IW'(k - quad_base);
  assign tab_addr = quad[0] ? (IW'(SINE_TABLE_DEPTH) - idx) : idx;
  assign entry    = sine_tab[tab_addr];
  assign sample   = quad[1] ? -$signed(entry) : $signed(entry);

endmodule

// ===== sv/wsn_ramp.sv =====
// ----------------------------------------------------------------------------
// wsn_ramp: square, saw and triangle shapes
// Computes the three piecewise linear shapes straight from the phase and
// saturates the saw and the triangle to Q1.15.
// ----------------------------------------------------------------------------
module wsn_ramp #(
  parameter int PHASE_BITS = 16
) (
  input  logic [PHASE_BITS-1:0] phase,
  output wsn_pkg::sample_t      square,
  output wsn_pkg::sample_t      saw,
  output wsn_pkg::sample_t      triangle
);

  localparam int PW  = PHASE_BITS;
  localparam int SHW = PW + 17;

  logic [PW-1:0]       shifted;
  logic [PW:0]         twice;
  logic [PW:0]         full;
  logic [PW:0]         tri_dist;
  logic [SHW-1:0]      saw_scaled;
  logic [SHW-1:0]      tri_scaled;
  logic signed [17:0]  saw_raw;
  logic signed [17:0]  tri_raw;

  // Square: full scale in the first half turn.
  assign square = phase[PW-1] ? '0 : wsn_pkg::Q15_MAX;

  // Saw: phase rescaled to 16 bits, falling from +1.
  assign saw_scaled = (SHW'(phase) << 16) >> PW;
  assign saw_raw    = 18'sd32768 - $signed({1'b0, saw_scaled[16:0]});
  assign saw = (saw_raw > 18'sd32767) ? wsn_pkg::Q15_MAX : saw_raw[15:0];

  // Triangle: distance of the shifted phase from half a turn.
  assign shifted    = phase + (PW'(1) << (PW - 2));
  assign twice      = {shifted, 1'b0};
  assign full       = (PW + 1)'(1) << PW;
  assign tri_dist   = (twice >= full) ? (twice - full) : (full - twice);
  assign tri_scaled = (SHW'(tri_dist) << 16) >> PW;
  assign tri_raw    = 18'sd32768 - $signed({1'b0, tri_scaled[16:0]});
  assign triangle = (tri_raw > 18'sd32767) ? wsn_pkg::Q15_MAX : tri_raw[15:0];

endmodule

// ===== sv/wsn_noise.sv =====
// ----------------------------------------------------------------------------
// wsn_noise: white noise generator
// Two 32-bit registers: an xor step followed by an add step per sample.
// The sample is the top half of the sum register before it advances.
// ----------------------------------------------------------------------------
module wsn_noise (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  output wsn_pkg::sample_t sample
);

  logic [31:0] mix_r;
  logic [31:0] mix_nxt;
  logic [31:0] sum_r;
  logic [31:0] sum_nxt;

  // Next state of the generator when a sample is taken.
  always_comb begin
    mix_nxt = mix_r;
    sum_nxt = sum_r;
    if (step) begin
      mix_nxt = mix_r ^ sum_r;
      sum_nxt = sum_r + mix_nxt;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= wsn_pkg::NOISE_MIX_RESET;
      sum_r <= wsn_pkg::NOISE_SUM_RESET;
    end else begin
      mix_r <= mix_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign sample = $signed(sum_r[31:16]);

  // The generator holds when no sample is taken.
  a_noise_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mix_r) && $stable(sum_r))
    else $error("noise state changed without a step");

  // A step mixes the old sum into the mix register and adds the new mix to the sum.
  a_noise_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (mix_r == ($past(mix_r) ^ $past(sum_r))) &&
             (sum_r == $past(sum_r) + mix_r))
    else $error("noise step produced a wrong state");

endmodule

// ===== tb/waveform_shaper_with_noise_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_shaper_with_noise_tb: self-checking bench for the waveform shaper
// Drives phase requests in every shape, predicts each sample in the bench and
// compares it with the block's output, with random stalls on both channels.
// ----------------------------------------------------------------------------
module waveform_shaper_with_noise_tb;

  // Unused shape codes; the block answers them with a zero sample.
  localparam wsn_pkg::shape_t SHAPE_RSVD_LO = 3'd5;
  localparam wsn_pkg::shape_t SHAPE_RSVD_HI = 3'd7;

  localparam int TABLE_DEPTH = 256;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT = 31;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [wsn_pkg::SHAPE_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] phase_word
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] sample_out

  // Bench copy of the block's state and the shape register.
  wsn_pkg::shape_t model_shape;
  logic [31:0] model_noise_mix;
  logic [31:0] model_noise_sum;
  int quarter_sine [0:TABLE_DEPTH];

  wsn_pkg::sample_t expected_samples [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit stalls_enabled = 1'b1;

  waveform_shaper_with_noise i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Quarter-wave entry j as Q15, from a Q30 Taylor series of the sine.
  function automatic int quarter_sine_entry(int j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned dv;
    x = (Q30_HALF_PI * longint'(j)) / TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int n = 0; n < 6; n++) begin
      case (n)
        0: dv = 156;
        1: dv = 110;
        2: dv = 72;
        3: dv = 42;
        4: dv = 20;
        default: dv = 6;
      endcase
      t = Q30_ONE - ((x2 * t) >> 30) / dv;
    end
    s = (x * t) >> 30;
    return int'((s * 32767 + (Q30_ONE >> 1)) >> 30);
  endfunction

  // Expected sample for one phase; the noise state advances in the noise shape.
  function automatic wsn_pkg::sample_t predict_sample(logic [15:0] phase);
    int p;
    int v;
    int g;
    int d;
    logic [9:0] k;
    p = phase;
    case (model_shape)
      wsn_pkg::SHAPE_SINE: begin
        // Top ten bits pick the quadrant and the table slot.
        k = phase[15:6];
        v = quarter_sine[k[8] ? TABLE_DEPTH - k[7:0] : k[7:0]];
        if (k[9]) v = -v;
      end
      wsn_pkg::SHAPE_SQUARE: v = (p < 32768) ? 32767 : 0;
      wsn_pkg::SHAPE_SAW: v = 32768 - p;
      wsn_pkg::SHAPE_TRIANGLE: begin
        g = (p + 16384) & 65535;
        d = 2 * g - 65536;
        if (d < 0) d = -d;
        v = 32768 - d;
      end
      wsn_pkg::SHAPE_NOISE: begin
        model_noise_mix = model_noise_mix ^ model_noise_sum;
        v = wsn_pkg::sample_t'(model_noise_sum[31:16]);
        model_noise_sum = model_noise_sum + model_noise_mix;
      end
      default: v = 0;
    endcase
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return wsn_pkg::sample_t'(v);
  endfunction

  // Mostly uniform phases, the rest close to the quadrant boundaries.
  function automatic logic [15:0] random_phase();
    logic [15:0] corner;
    if ($urandom_range(0, 99) < 80) return 16'($urandom);
    corner = 16'($urandom_range(0, 3)) << 14;
    return corner + 16'($urandom_range(0, 4)) - 16'd2;
  endfunction

  function automatic wsn_pkg::shape_t random_shape();
    if ($urandom_range(0, 9) == 0)
      return wsn_pkg::shape_t'($urandom_range(SHAPE_RSVD_LO, SHAPE_RSVD_HI));
    return wsn_pkg::shape_t'($urandom_range(wsn_pkg::SHAPE_SINE, wsn_pkg::SHAPE_NOISE));
  endfunction

  // Result side: random back-pressure while stalls are enabled.
  always @(posedge clk) begin
    out_tready <= !(stalls_enabled && $urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Tracks configuration and requests, checks every sample, runs the watchdog.
  always @(posedge clk) begin : sample_checker
    wsn_pkg::sample_t want;
    if (!rst_n) begin
      model_shape = wsn_pkg::SHAPE_SINE;
      model_noise_mix = wsn_pkg::NOISE_MIX_RESET;
      model_noise_sum = wsn_pkg::NOISE_SUM_RESET;
      quiet_cycles = 0;
    end else begin
      if (cfg_wr_en) model_shape = cfg_wr_data;
      if (in_tvalid && in_tready) expected_samples.push_back(predict_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected sample %0d with no request pending",
                 $signed(out_tdata));
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, $signed(out_tdata));
            mismatch_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Sends one phase request, with random idle cycles ahead of it.
  task automatic send_phase(logic [15:0] phase);
    while (stalls_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= phase;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every expected sample has come back.
  task automatic wait_for_samples();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // Changes the shape once the block has nothing in flight.
  task automatic write_shape(wsn_pkg::shape_t shape);
    wait_for_samples();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= shape;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Quadrant edges, ramp ends, square step, held noise state and unused codes.
  task automatic test_directed_corners();
    write_shape(wsn_pkg::SHAPE_SINE);
    send_phase(16'h0000);
    send_phase(16'h4000);
    send_phase(16'h8000);
    send_phase(16'hc000);
    send_phase(16'hffff);
    write_shape(wsn_pkg::SHAPE_SQUARE);
    send_phase(16'h7fff);
    send_phase(16'h8000);
    write_shape(wsn_pkg::SHAPE_SAW);
    send_phase(16'h0000);
    send_phase(16'h0001);
    send_phase(16'h8000);
    send_phase(16'hffff);
    write_shape(wsn_pkg::SHAPE_TRIANGLE);
    send_phase(16'h0000);
    send_phase(16'h4000);
    send_phase(16'h8000);
    send_phase(16'hc000);
    write_shape(wsn_pkg::SHAPE_NOISE);
    send_phase(16'h0000);
    send_phase(16'hffff);
    write_shape(SHAPE_RSVD_LO);
    send_phase(16'h5555);
    write_shape(SHAPE_RSVD_HI);
    send_phase(16'haaaa);
    // Noise must carry on from where it stopped.
    write_shape(wsn_pkg::SHAPE_NOISE);
    send_phase(16'h1234);
    send_phase(16'hedcb);
  endtask

  // Full rate in both directions, no stalls at all.
  task automatic test_back_to_back();
    stalls_enabled = 1'b0;
    write_shape(wsn_pkg::SHAPE_NOISE);
    repeat (40) send_phase(random_phase());
    write_shape(wsn_pkg::SHAPE_SINE);
    repeat (40) send_phase(random_phase());
    write_shape(wsn_pkg::SHAPE_TRIANGLE);
    repeat (40) send_phase(random_phase());
    write_shape(wsn_pkg::SHAPE_SAW);
    repeat (40) send_phase(random_phase());
    stalls_enabled = 1'b1;
  endtask

  // Random shape per run, random phases, stalls on both sides.
  task automatic test_random_shapes();
    repeat (12) begin
      write_shape(random_shape());
      repeat ($urandom_range(30, 70)) send_phase(random_phase());
    end
  endtask

  // Sender holds off mid-run until the pipeline is empty, then resumes.
  task automatic test_drain_pause();
    write_shape(wsn_pkg::SHAPE_NOISE);
    repeat (30) send_phase(random_phase());
    wait_for_samples();
    repeat (30) send_phase(random_phase());
    write_shape(wsn_pkg::SHAPE_SQUARE);
    repeat (20) send_phase(random_phase());
  endtask

  initial begin
    for (int j = 0; j <= TABLE_DEPTH; j++) quarter_sine[j] = quarter_sine_entry(j);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_back_to_back();
    test_random_shapes();
    test_drain_pause();
    wait_for_samples();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wsn_pkg.sv
sv/wsn_sine.sv
sv/wsn_ramp.sv
sv/wsn_noise.sv
sv/waveform_shaper_with_noise.sv
tb/waveform_shaper_with_noise_tb.sv
